// ----- src/shlex_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shlex_pkg
// Shared types and constants of the shell command lexer: character codes,
// token kinds, lexer states and the token record passed through the queue.
// ----------------------------------------------------------------------------
package shlex_pkg;

	localparam logic [7:0] CH_BAR    = 8'h7C;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_OPEN   = 8'h28;
	localparam logic [7:0] CH_CLOSE  = 8'h29;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;

	localparam logic [3:0] K_WORD    = 4'd0;
	localparam logic [3:0] K_PIPE    = 4'd1;
	localparam logic [3:0] K_OR      = 4'd2;
	localparam logic [3:0] K_AND     = 4'd3;
	localparam logic [3:0] K_HEREDOC = 4'd4;
	localparam logic [3:0] K_IN      = 4'd5;
	localparam logic [3:0] K_APPEND  = 4'd6;
	localparam logic [3:0] K_OUT     = 4'd7;
	localparam logic [3:0] K_OPEN    = 4'd8;
	localparam logic [3:0] K_CLOSE   = 4'd9;

	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [3:0] {
		M_IDLE   = 4'b0001,
		M_WORD   = 4'b0010,
		M_SQUOTE = 4'b0100,
		M_DQUOTE = 4'b1000
	} lex_mode_t;

	typedef enum logic [4:0] {
		P_NONE = 5'b00001,
		P_BAR  = 5'b00010,
		P_AMP  = 5'b00100,
		P_LT   = 5'b01000,
		P_GT   = 5'b10000
	} pend_op_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [11:0] start;
		logic [7:0]  length;
		logic        sat;
		logic        unq;
	} tok_t;

	typedef struct packed {
		logic two;
		tok_t tok1;
		tok_t tok0;
	} tok_pair_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic tok_t make_tok(logic [3:0] kind, logic [11:0] start,
	                                  logic [7:0] length, logic sat, logic unq);
		tok_t t;
		t.kind   = kind;
		t.start  = start;
		t.length = length;
		t.sat    = sat;
		t.unq    = unq;
		return t;
	endfunction

endpackage

// ----- src/shlex_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shlex_front
// Lexer front end: accepts one byte a beat, updates the lexer state and
// produces the zero, one or two tokens that the byte completes.
// ----------------------------------------------------------------------------
module shlex_front import shlex_pkg::*; #(
	parameter int LINE_POSITIONS   = 4096,
	parameter int MAX_TOKEN_LENGTH = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] char_code,
	input  logic       end_of_line,
	output logic [1:0] tok_count,
	output tok_pair_t  toks
);

	localparam int POS_W = $clog2(LINE_POSITIONS);
	localparam int LEN_W = $clog2(MAX_TOKEN_LENGTH + 1);

	lex_mode_t          mode_q, mode_n;
	pend_op_t           pend_q, pend_n, pend_old;
	logic [POS_W-1:0]   ws_q, ws_n, pos_q, pos_n, prev;
	logic [LEN_W-1:0]   wl_q, wl_n;
	logic               wo_q, wo_n;
	logic               consumed;
	logic [1:0]         cnt;
	tok_t [1:0]         tk;
	logic [7:0]         same;
	logic [3:0]         kind_two, kind_one, kind_eol;

	assign prev = (pos_q == '0) ? POS_W'(LINE_POSITIONS - 1) : pos_q - POS_W'(1);

	always_comb begin
		mode_n   = mode_q;
		pend_n   = pend_q;
		pend_old = pend_q;
		ws_n     = ws_q;
		wl_n     = wl_q;
		wo_n     = wo_q;
		pos_n    = pos_q;
		consumed = 1'b0;
		cnt      = 2'd0;
		tk       = '0;
		same     = CH_GT;
		kind_two = K_APPEND;
		kind_one = K_OUT;
		kind_eol = K_OUT;

		// resolve the pending operator against this byte
		if (pend_old != P_NONE) begin
			pend_n = P_NONE;
			if (pend_old == P_AMP) begin
				if (char_code == CH_AMP) begin
					if (mode_n == M_WORD) begin
						if (cnt != 2'd2) begin
							tk[cnt[0]] = make_tok(K_WORD, 12'(ws_n), 8'(wl_n), wo_n, 1'b0);
							cnt = cnt + 2'd1;
						end
						wl_n   = '0;
						wo_n   = 1'b0;
						mode_n = M_IDLE;
					end
					if (cnt != 2'd2) begin
						tk[cnt[0]] = make_tok(K_AND, 12'(prev), 8'd2, 1'b0, 1'b0);
						cnt = cnt + 2'd1;
					end
					consumed = 1'b1;
				end else begin
					if (mode_n == M_IDLE) begin
						ws_n   = prev;
						wl_n   = '0;
						wo_n   = 1'b0;
						mode_n = M_WORD;
					end
					if (wl_n < LEN_W'(MAX_TOKEN_LENGTH))
						wl_n = wl_n + LEN_W'(1);
					else
						wo_n = 1'b1;
				end
			end else begin
				if (pend_old == P_BAR) begin
					same     = CH_BAR;
					kind_two = K_OR;
					kind_one = K_PIPE;
				end else if (pend_old == P_LT) begin
					same     = CH_LT;
					kind_two = K_HEREDOC;
					kind_one = K_IN;
				end
				if (char_code == same) begin
					if (cnt != 2'd2) begin
						tk[cnt[0]] = make_tok(kind_two, 12'(prev), 8'd2, 1'b0, 1'b0);
						cnt = cnt + 2'd1;
					end
					consumed = 1'b1;
				end else if (cnt != 2'd2) begin
					tk[cnt[0]] = make_tok(kind_one, 12'(prev), 8'd1, 1'b0, 1'b0);
					cnt = cnt + 2'd1;
				end
			end
		end

		// handle the byte itself
		if (!consumed) begin
			if (mode_n == M_SQUOTE || mode_n == M_DQUOTE) begin
				if (wl_n < LEN_W'(MAX_TOKEN_LENGTH))
					wl_n = wl_n + LEN_W'(1);
				else
					wo_n = 1'b1;
				if ((mode_n == M_SQUOTE && char_code == CH_SQUOTE) ||
				    (mode_n == M_DQUOTE && char_code == CH_DQUOTE))
					mode_n = M_WORD;
			end else if (char_code inside {CH_SPACE, CH_TAB, CH_NL}) begin
				if (mode_n == M_WORD) begin
					if (cnt != 2'd2) begin
						tk[cnt[0]] = make_tok(K_WORD, 12'(ws_n), 8'(wl_n), wo_n, 1'b0);
						cnt = cnt + 2'd1;
					end
					wl_n   = '0;
					wo_n   = 1'b0;
					mode_n = M_IDLE;
				end
			end else if (char_code inside {CH_SQUOTE, CH_DQUOTE}) begin
				if (mode_n == M_IDLE) begin
					ws_n = pos_q;
					wl_n = '0;
					wo_n = 1'b0;
				end
				if (wl_n < LEN_W'(MAX_TOKEN_LENGTH))
					wl_n = wl_n + LEN_W'(1);
				else
					wo_n = 1'b1;
				mode_n = (char_code == CH_SQUOTE) ? M_SQUOTE : M_DQUOTE;
			end else if (char_code inside {CH_BAR, CH_LT, CH_GT}) begin
				if (mode_n == M_WORD) begin
					if (cnt != 2'd2) begin
						tk[cnt[0]] = make_tok(K_WORD, 12'(ws_n), 8'(wl_n), wo_n, 1'b0);
						cnt = cnt + 2'd1;
					end
					wl_n   = '0;
					wo_n   = 1'b0;
					mode_n = M_IDLE;
				end
				pend_n = (char_code == CH_BAR) ? P_BAR : (char_code == CH_LT) ? P_LT : P_GT;
			end else if (char_code == CH_AMP) begin
				pend_n = P_AMP;
			end else if (char_code inside {CH_OPEN, CH_CLOSE}) begin
				if (mode_n == M_WORD) begin
					if (cnt != 2'd2) begin
						tk[cnt[0]] = make_tok(K_WORD, 12'(ws_n), 8'(wl_n), wo_n, 1'b0);
						cnt = cnt + 2'd1;
					end
					wl_n   = '0;
					wo_n   = 1'b0;
					mode_n = M_IDLE;
				end
				if (cnt != 2'd2) begin
					tk[cnt[0]] = make_tok((char_code == CH_OPEN) ? K_OPEN : K_CLOSE,
					                      12'(pos_q), 8'd1, 1'b0, 1'b0);
					cnt = cnt + 2'd1;
				end
			end else begin
				if (mode_n == M_IDLE) begin
					ws_n   = pos_q;
					wl_n   = '0;
					wo_n   = 1'b0;
					mode_n = M_WORD;
				end
				if (wl_n < LEN_W'(MAX_TOKEN_LENGTH))
					wl_n = wl_n + LEN_W'(1);
				else
					wo_n = 1'b1;
			end
		end

		// flush at line end
		if (end_of_line) begin
			if (pend_n == P_AMP) begin
				if (mode_n == M_IDLE) begin
					ws_n   = pos_q;
					wl_n   = '0;
					wo_n   = 1'b0;
					mode_n = M_WORD;
				end
				if (wl_n < LEN_W'(MAX_TOKEN_LENGTH))
					wl_n = wl_n + LEN_W'(1);
				else
					wo_n = 1'b1;
			end else if (pend_n != P_NONE) begin
				kind_eol = (pend_n == P_BAR) ? K_PIPE : (pend_n == P_LT) ? K_IN : K_OUT;
				if (cnt != 2'd2) begin
					tk[cnt[0]] = make_tok(kind_eol, 12'(pos_q), 8'd1, 1'b0, 1'b0);
					cnt = cnt + 2'd1;
				end
			end
			if (mode_n != M_IDLE && cnt != 2'd2) begin
				tk[cnt[0]] = make_tok(K_WORD, 12'(ws_n), 8'(wl_n), wo_n, mode_n != M_WORD);
				cnt = cnt + 2'd1;
			end
			mode_n = M_IDLE;
			pend_n = P_NONE;
			ws_n   = '0;
			wl_n   = '0;
			wo_n   = 1'b0;
			pos_n  = '0;
		end else begin
			pos_n = (pos_q == POS_W'(LINE_POSITIONS - 1)) ? '0 : pos_q + POS_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			pend_q <= P_NONE;
			ws_q   <= '0;
			wl_q   <= '0;
			wo_q   <= 1'b0;
			pos_q  <= '0;
		end else if (accept) begin
			mode_q <= mode_n;
			pend_q <= pend_n;
			ws_q   <= ws_n;
			wl_q   <= wl_n;
			wo_q   <= wo_n;
			pos_q  <= pos_n;
		end
	end

	assign tok_count = cnt;
	assign toks.two  = (cnt == 2'd2);
	assign toks.tok0 = tk[0];
	assign toks.tok1 = tk[1];

endmodule

// ----- src/shlex_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shlex_queue
// Short token queue between lexer front end and output stage; one entry
// holds all tokens completed by one byte.
// ----------------------------------------------------------------------------
module shlex_queue import shlex_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  tok_pair_t push_data,
	input  logic      pop,
	output tok_pair_t pop_data,
	output q_status_t status
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	tok_pair_t        mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign status.full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign status.empty = (cnt_q == '0);
	assign pop_data     = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			if (pop)
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

endmodule

// ----- src/shlex_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shlex_back
// Output stage: takes queue entries and sends their tokens one beat each,
// marking the last token of each entry.
// ----------------------------------------------------------------------------
module shlex_back import shlex_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  q_status_t status,
	input  tok_pair_t pop_data,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_ready,
	output tok_t      out_tok,
	output logic      out_last
);

	tok_pair_t entry_q;
	logic      valid_q;
	logic      sel_q;
	logic      last_beat;

	assign last_beat = sel_q || !entry_q.two;
	assign pop       = !status.empty && (!valid_q || (out_ready && last_beat));
	assign out_valid = valid_q;
	assign out_tok   = sel_q ? entry_q.tok1 : entry_q.tok0;
	assign out_last  = last_beat;

	always_ff @(posedge clk) begin
		if (pop)
			entry_q <= pop_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
			sel_q   <= 1'b0;
		end else if (valid_q && out_ready) begin
			if (last_beat)
				valid_q <= 1'b0;
			else
				sel_q <= 1'b1;
		end
	end

endmodule

// ----- src/shell_command_lexer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shell_command_lexer
// Streaming shell command line tokenizer, one byte per input beat.
// ----------------------------------------------------------------------------
// The block takes one byte of a command line every cycle (tlast marks the
// last byte of a line) and sends one token per output beat: kind in tuser,
// start, length and flags in tdata, tlast on the last token completed by a
// byte. The front end classifies a byte in the cycle it is accepted and
// pushes its tokens into a four-entry queue at that edge; the output stage
// then pops the entry into its own register, from which it sends the
// first token and then the second. Tokens still queued from earlier
// bytes and output stalls delay a token's output further. Input
// runs at one byte per cycle as long as the output keeps up, and the output
// port is the limit: a byte that completes two tokens needs two output
// beats, and input stalls only while the queue is full. There is no
// clearing pass after reset.
module shell_command_lexer import shlex_pkg::*; #(
	parameter int LINE_POSITIONS   = 4096,
	parameter int MAX_TOKEN_LENGTH = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
	input  logic        s_axis_tlast,   // end_of_line
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [11:0] token_start, [19:12] token_length,
	                                    // [20] length_saturated, [21] unterminated_quote
	output logic [3:0]  m_axis_tuser,   // [3:0] token_kind
	output logic        m_axis_tlast    // last_result
);

	logic      accept;
	logic [1:0] tok_count;
	tok_pair_t toks, pop_data;
	q_status_t status;
	logic      pop;
	tok_t      out_tok;

	assign s_axis_tready = !status.full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	shlex_front #(
		.LINE_POSITIONS  (LINE_POSITIONS),
		.MAX_TOKEN_LENGTH(MAX_TOKEN_LENGTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.char_code  (s_axis_tdata),
		.end_of_line(s_axis_tlast),
		.tok_count  (tok_count),
		.toks       (toks)
	);

	shlex_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept && (tok_count != 2'd0)),
		.push_data(toks),
		.pop      (pop),
		.pop_data (pop_data),
		.status   (status)
	);

	shlex_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.status   (status),
		.pop_data (pop_data),
		.pop      (pop),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_tok  (out_tok),
		.out_last (m_axis_tlast)
	);

	assign m_axis_tuser = out_tok.kind;
	assign m_axis_tdata = {2'b00, out_tok.unq, out_tok.sat, out_tok.length, out_tok.start};

endmodule
